### hw/rtl/phd_pkg.sv
// Shared widths, codes and types for the pairwise Hamming distance engine.
`default_nettype none
package phd_pkg;

	localparam int ROW_W     = 64;
	localparam int SLOT_W    = 6;
	localparam int DIST_W    = 7;
	localparam int CFG_W     = 7;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int CELL_BITS = 8;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic REG_REF_COUNT = 1'b0;
	localparam logic REG_VEC_LEN   = 1'b1;

	localparam logic [CFG_W-1:0] REF_COUNT_RST = 7'd1;
	localparam logic [CFG_W-1:0] VEC_LEN_RST   = 7'd64;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} cell_meta_t;

endpackage
`default_nettype wire

### hw/rtl/phd_if.sv
// Stream channel interfaces: query/load beats in, distance beats out.
`default_nettype none
interface phd_in_if;
	import phd_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [SLOT_W-1:0] ref_slot;
	logic [ROW_W-1:0]  row_bits;

	modport source (output valid, action, ref_slot, row_bits, input ready);
	modport sink   (input valid, action, ref_slot, row_bits, output ready);
endinterface

interface phd_out_if;
	import phd_pkg::*;

	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] match_slot;
	logic [DIST_W-1:0] distance;
	logic              last;

	modport source (output valid, match_slot, distance, last, input ready);
	modport sink   (input valid, match_slot, distance, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/pairwise_hamming_distance_top.sv
// Pairwise Hamming distance engine: reference store, issue sequencer, cell chain.
//
// in_ch carries load and query beats. A load (action 0) writes row_bits into
// the reference slot ref_slot; slots at or above MAX_REFS are dropped. A query
// (action 1) is compared against slots 0 .. ref_count-1 (ref_count capped at
// the store depth) in order and gives one out_ch beat per slot with the slot, the
// number of differing bits among the low vector_length columns, and last on
// the final beat. in_ch.ready is low while a query's slots are being issued
// (one memory read per cycle, held while out_ch stalls); a load does not
// block the input. The first result passes through the read stage, the cell
// chain and the output register; the rest follow one per cycle while out_ch
// does not stall. The popcount runs through a chain of cells, each adding eight
// columns per cycle.
// When out_ch stalls, the whole read/cell pipeline holds in place.
// ref_count and vector_length must be written over the APB port only while idle;
// the block itself does not enforce this. They reset to 1 and 64. Reset clears
// control state only; the store holds nothing defined until loaded.
`default_nettype none
module pairwise_hamming_distance_top #(
	parameter int MAX_REFS = 64,
	parameter int MAX_BITS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	phd_in_if.sink                            in_ch,
	phd_out_if.source                         out_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [phd_pkg::APB_AW-1:0]   paddr,
	input  wire logic [phd_pkg::APB_DW-1:0]   pwdata,
	output logic      [phd_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);
	import phd_pkg::*;

	localparam int DEPTH     = (MAX_REFS < 64) ? MAX_REFS : 64;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NUM_CELLS = (MAX_BITS + CELL_BITS - 1) / CELL_BITS;
	localparam int VEC_W     = NUM_CELLS * CELL_BITS;
	localparam int SUM_W     = $clog2(MAX_BITS + 1);

	// configuration
	logic [CFG_W-1:0] ref_count_q;
	logic [CFG_W-1:0] vec_len_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= REF_COUNT_RST;
			vec_len_q   <= VEC_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_REF_COUNT: ref_count_q <= pwdata[CFG_W-1:0];
				REG_VEC_LEN:   vec_len_q   <= pwdata[CFG_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_REF_COUNT: prdata = APB_DW'(ref_count_q);
			REG_VEC_LEN:   prdata = APB_DW'(vec_len_q);
			default:       prdata = '0;
		endcase
	end

	// effective counts
	logic [CFG_W-1:0] n_eff;
	logic [CFG_W-1:0] vl_eff;
	logic [VEC_W-1:0] col_mask;

	assign n_eff  = (ref_count_q > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : ref_count_q;
	assign vl_eff = (vec_len_q > CFG_W'(MAX_BITS)) ? CFG_W'(MAX_BITS) : vec_len_q;

	always_comb begin
		for (int i = 0; i < VEC_W; i++) begin
			col_mask[i] = (CFG_W'(i) < vl_eff);
		end
	end

	// input side and issue sequencer
	logic                in_fire;
	logic                adv;
	logic                busy_q;
	logic [SLOT_W-1:0]   k_q;
	logic [CFG_W-1:0]    n_q;
	logic [MAX_BITS-1:0] query_q;
	logic                iss_last;
	logic                load_we;

	assign in_ch.ready = !busy_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign iss_last    = ({1'b0, k_q} == n_q - 7'd1);
	assign load_we     = in_fire && (in_ch.action == ACT_LOAD)
		&& ({1'b0, in_ch.ref_slot} < CFG_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			n_q    <= '0;
		end else if (in_fire && (in_ch.action == ACT_QUERY)) begin
			busy_q <= (n_eff != '0);
			k_q    <= '0;
			n_q    <= n_eff;
		end else if (busy_q && adv) begin
			k_q <= k_q + 6'd1;
			if (iss_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_ch.action == ACT_QUERY)) begin
			query_q <= in_ch.row_bits[MAX_BITS-1:0];
		end
	end

	// read stage
	logic [MAX_BITS-1:0] ref_s1;
	logic [VEC_W-1:0]    row_s1;
	cell_meta_t          meta_s1;

	phd_store #(
		.DEPTH (DEPTH),
		.WIDTH (MAX_BITS),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.we       (load_we),
		.waddr    (in_ch.ref_slot[AW-1:0]),
		.wdata    (in_ch.row_bits[MAX_BITS-1:0]),
		.re       (adv),
		.raddr    (k_q[AW-1:0]),
		.rdata_s1 (ref_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (adv) begin
			meta_s1.valid <= busy_q;
			meta_s1.slot  <= k_q;
			meta_s1.last  <= iss_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1 <= VEC_W'(query_q);
		end
	end

	// cell chain
	cell_meta_t       meta_c [NUM_CELLS+1];
	logic [VEC_W-1:0] vec_c  [NUM_CELLS+1];
	logic [SUM_W-1:0] sum_c  [NUM_CELLS+1];

	assign meta_c[0] = meta_s1;
	assign vec_c[0]  = (row_s1 ^ VEC_W'(ref_s1)) & col_mask;
	assign sum_c[0]  = '0;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		phd_cell #(
			.VEC_W (VEC_W),
			.SUM_W (SUM_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.meta_in (meta_c[g]),
			.vec_in  (vec_c[g]),
			.sum_in  (sum_c[g]),
			.meta_q  (meta_c[g+1]),
			.vec_q   (vec_c[g+1]),
			.sum_q   (sum_c[g+1])
		);
	end

	// output register
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_last_q;

	// advance everything when the output slot is free or being taken
	assign adv = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= meta_c[NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_slot_q <= meta_c[NUM_CELLS].slot;
			out_dist_q <= DIST_W'(sum_c[NUM_CELLS]);
			out_last_q <= meta_c[NUM_CELLS].last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.match_slot = out_slot_q;
	assign out_ch.distance   = out_dist_q;
	assign out_ch.last       = out_last_q;

	// checks
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, k_q} < n_q))
		else $error("issue index past reference count");

	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(adv && iss_last) |=> busy_q)
		else $error("issue stopped before last reference");

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_ch.action == ACT_QUERY) && (n_eff != '0) |=> busy_q && (k_q == '0))
		else $error("query did not start issue at slot zero");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(meta_c[NUM_CELLS]))
		else $error("cell chain moved during output stall");
endmodule
`default_nettype wire

### hw/rtl/phd_store.sv
// Reference row memory: one write port, one registered read port.
`default_nettype none
module phd_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata_s1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/phd_cell.sv
// One popcount cell: counts the low bits of its word, adds, shifts on.
`default_nettype none
module phd_cell #(
	parameter int VEC_W = 64,
	parameter int SUM_W = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire phd_pkg::cell_meta_t meta_in,
	input  wire logic [VEC_W-1:0]    vec_in,
	input  wire logic [SUM_W-1:0]    sum_in,
	output phd_pkg::cell_meta_t      meta_q,
	output logic      [VEC_W-1:0]    vec_q,
	output logic      [SUM_W-1:0]    sum_q
);
	import phd_pkg::*;

	logic [SUM_W-1:0] cnt;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < CELL_BITS; i++) begin
			cnt = cnt + SUM_W'(vec_in[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q <= '0;
		end else if (en) begin
			meta_q <= meta_in;
		end
	end

	// drop the counted bits, hand the rest to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= vec_in >> CELL_BITS;
			sum_q <= sum_in + cnt;
		end
	end
endmodule
`default_nettype wire

### bench/tb_pairwise_hamming_distance_top.sv
// Self-checking bench for the pairwise Hamming distance engine top level.
`timescale 1ns / 1ps
module tb_pairwise_hamming_distance_top;
	import phd_pkg::*;

	localparam int REF_SLOTS     = 64;
	localparam int COL_LIMIT     = 64;
	localparam int SETTLE_CYCLES = 3 * ((COL_LIMIT + CELL_BITS - 1) / CELL_BITS + 3);

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [DIST_W-1:0] ones;
		logic              is_last;
	} distance_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	phd_in_if  in_ch();
	phd_out_if out_ch();

	pairwise_hamming_distance_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// shadow of the block's state
	logic [ROW_W-1:0] ref_rows [REF_SLOTS];
	logic [CFG_W-1:0] cfg_ref_count = REF_COUNT_RST;
	logic [CFG_W-1:0] cfg_vec_len   = VEC_LEN_RST;
	distance_beat_t   expected_distances [$];

	int fail_count   = 0;
	int gap_max      = 0;
	int burst_left   = 0;
	int hold_request = 0;

	function automatic void predict_distances(input logic act, input logic [SLOT_W-1:0] slot,
			input logic [ROW_W-1:0] row);
		int n;
		logic [ROW_W-1:0] mask;
		distance_beat_t beat;
		if (act == ACT_LOAD) begin
			ref_rows[slot] = row;
			return;
		end
		n = (cfg_ref_count > REF_SLOTS) ? REF_SLOTS : int'(cfg_ref_count);
		if (cfg_vec_len >= COL_LIMIT)
			mask = '1;
		else
			mask = (64'd1 << cfg_vec_len) - 64'd1;
		for (int k = 0; k < n; k++) begin
			beat.slot    = SLOT_W'(k);
			beat.ones    = DIST_W'($countones((row ^ ref_rows[k]) & mask));
			beat.is_last = (k == n - 1);
			expected_distances.push_back(beat);
		end
	endfunction

	function automatic logic [ROW_W-1:0] random_row();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// bias queries toward stored rows so small distances show up
	function automatic logic [ROW_W-1:0] query_row();
		logic [ROW_W-1:0] row;
		if ($urandom_range(0, 2) != 0)
			return random_row();
		row = ref_rows[$urandom_range(0, REF_SLOTS - 1)];
		repeat ($urandom_range(0, 3))
			row[$urandom_range(0, ROW_W - 1)] ^= 1'b1;
		return row;
	endfunction

	task automatic send_beat(input logic act, input logic [SLOT_W-1:0] slot,
			input logic [ROW_W-1:0] row);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid    <= 1'b1;
		in_ch.action   <= act;
		in_ch.ref_slot <= slot;
		in_ch.row_bits <= row;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predict_distances(act, slot, row);
	endtask

	// drop valid, wait for every expected beat, then let the pipeline empty
	task automatic settle_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_distances.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic reg_index, input logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= {$urandom_range(0, 1) ? 25'h1ffffff : 25'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (reg_index == REG_REF_COUNT)
			cfg_ref_count = value;
		else
			cfg_vec_len = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[CFG_W-1:0] !== value) begin
			$error("register %0d readback expected %0d got %0d", reg_index, value,
				readback[CFG_W-1:0]);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_distances
		distance_beat_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_distances.size() == 0) begin
				$error("unexpected beat match_slot %0d distance %0d last %0b",
					out_ch.match_slot, out_ch.distance, out_ch.last);
				fail_count++;
			end else begin
				want = expected_distances.pop_front();
				if (out_ch.match_slot !== want.slot) begin
					$error("match_slot expected %0d got %0d", want.slot, out_ch.match_slot);
					fail_count++;
				end
				if (out_ch.distance !== want.ones) begin
					$error("distance expected %0d got %0d", want.ones, out_ch.distance);
					fail_count++;
				end
				if (out_ch.last !== want.is_last) begin
					$error("last expected %0b got %0b", want.is_last, out_ch.last);
					fail_count++;
				end
			end
		end
	end

	// receiver pacing: segments of steady, light or heavy stalling, plus requested holds
	initial begin : sink_pacing
		int mode_left;
		int hold_left;
		int ready_pct;
		mode_left = 0;
		hold_left = 0;
		ready_pct = 100;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(10, 80);
					case ($urandom_range(0, 3))
						0: ready_pct = 100;
						1: ready_pct = 75;
						2: ready_pct = 50;
						default: ready_pct = 20;
					endcase
				end
				mode_left--;
				out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	task automatic test_reset_defaults();
		gap_max = 2;
		send_beat(ACT_LOAD, 6'd0, '1);
		send_beat(ACT_QUERY, 6'd0, '0);
		send_beat(ACT_QUERY, 6'h3f, '1);
		send_beat(ACT_LOAD, 6'd63, '0);
	endtask

	task automatic test_column_window();
		settle_idle();
		write_register(REG_REF_COUNT, 7'd4);
		write_register(REG_VEC_LEN, 7'd64);
		send_beat(ACT_LOAD, 6'd1, 64'haaaa_aaaa_aaaa_aaaa);
		send_beat(ACT_LOAD, 6'd2, 64'h8000_0000_0000_0000);
		send_beat(ACT_LOAD, 6'd3, 64'h0000_0000_0000_0001);
		send_beat(ACT_QUERY, 6'd0, '0);
		send_beat(ACT_QUERY, 6'd0, '1);
		send_beat(ACT_QUERY, 6'd0, 64'h5555_5555_5555_5555);
		settle_idle();
		write_register(REG_VEC_LEN, 7'd1);
		send_beat(ACT_QUERY, 6'd0, '1);
		send_beat(ACT_QUERY, 6'd0, 64'hffff_ffff_ffff_fffe);
		settle_idle();
		write_register(REG_VEC_LEN, 7'd0);
		send_beat(ACT_QUERY, 6'd0, {$urandom(), $urandom()});
		settle_idle();
		write_register(REG_VEC_LEN, 7'd127);
		send_beat(ACT_QUERY, 6'd0, 64'h5555_5555_5555_5555);
		settle_idle();
		write_register(REG_VEC_LEN, 7'd63);
		send_beat(ACT_QUERY, 6'd0, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_ref_count_edges();
		settle_idle();
		write_register(REG_REF_COUNT, 7'd0);
		send_beat(ACT_QUERY, 6'd0, '1);
		send_beat(ACT_LOAD, 6'd5, {$urandom(), $urandom()});
		settle_idle();
		write_register(REG_REF_COUNT, 7'd1);
		send_beat(ACT_QUERY, 6'd0, '0);
	endtask

	task automatic test_full_store();
		settle_idle();
		for (int s = 0; s < REF_SLOTS; s++)
			send_beat(ACT_LOAD, SLOT_W'(s), random_row());
		settle_idle();
		write_register(REG_REF_COUNT, 7'd127);
		write_register(REG_VEC_LEN, 7'd64);
		send_beat(ACT_QUERY, 6'd0, random_row());
		settle_idle();
		write_register(REG_REF_COUNT, 7'd64);
		send_beat(ACT_QUERY, 6'd0, random_row());
	endtask

	task automatic run_traffic_phase(input logic [CFG_W-1:0] ref_count,
			input logic [CFG_W-1:0] vec_len, input int beats, input int gap);
		settle_idle();
		write_register(REG_REF_COUNT, ref_count);
		write_register(REG_VEC_LEN, vec_len);
		gap_max = gap;
		repeat (beats) begin
			if ($urandom_range(0, 99) < 45)
				send_beat(ACT_QUERY, SLOT_W'($urandom()), query_row());
			else
				send_beat(ACT_LOAD, SLOT_W'($urandom()), random_row());
		end
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(7'd64, 7'd64, 10, 0);
		run_traffic_phase(7'd127, 7'd127, 8, 3);
		run_traffic_phase(7'd1, 7'd1, 8, 10);
		run_traffic_phase(7'd0, 7'd40, 6, 2);
		repeat (3)
			run_traffic_phase(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 127)),
				6, $urandom_range(0, 6));
	endtask

	// hold the receiver off while the sender keeps offering beats
	task automatic test_backpressure();
		settle_idle();
		write_register(REG_REF_COUNT, 7'd16);
		write_register(REG_VEC_LEN, 7'd64);
		gap_max = 0;
		hold_request = 400;
		repeat (25) begin
			if ($urandom_range(0, 3) != 0)
				send_beat(ACT_QUERY, SLOT_W'($urandom()), query_row());
			else
				send_beat(ACT_LOAD, SLOT_W'($urandom()), random_row());
		end
	endtask

	initial begin
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_ch.valid    = 1'b0;
		in_ch.action   = ACT_LOAD;
		in_ch.ref_slot = '0;
		in_ch.row_bits = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_column_window();
		test_ref_count_edges();
		test_full_store();
		test_random_traffic();
		test_backpressure();
		settle_idle();
		if (fail_count == 0)
			$display("pairwise_hamming_distance_top regression: pass");
		else
			$display("pairwise_hamming_distance_top regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("pairwise_hamming_distance_top regression: fail");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/phd_pkg.sv
hw/rtl/phd_if.sv
hw/rtl/phd_store.sv
hw/rtl/phd_cell.sv
hw/rtl/pairwise_hamming_distance_top.sv
bench/tb_pairwise_hamming_distance_top.sv
